FILE: design/ccmap_pkg.sv
// Shared types and constants for the MIDI control-change fader mapper.
// Used by ccmap_cell, ccmap_scale and midi_cc_learn_fader_mapper; no dependencies.
package ccmap_pkg;

  localparam int FADER_COUNT_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 11;

  localparam logic [2:0] OP_MIDI   = 3'd0;
  localparam logic [2:0] OP_ARM    = 3'd1;
  localparam logic [2:0] OP_CANCEL = 3'd2;
  localparam logic [2:0] OP_LOAD   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [1:0] REG_ACTIVE  = 2'd0;
  localparam logic [1:0] REG_CHANNEL = 2'd1;
  localparam logic [1:0] REG_DEVICE  = 2'd2;

  localparam logic [4:0] ACTIVE_RESET = 5'd8;
  localparam logic [3:0] CC_STATUS    = 4'hB;

  // Reciprocal of 127 scaled by 2^30; exact floor for dividends below 2^23.
  localparam int          RECIP_SHIFT = 30;
  localparam int          PROD_W      = 48;
  localparam logic [23:0] RECIP_127   = 24'd8454661;

  typedef struct packed {
    logic       live;
    logic       learn;
    logic [3:0] learn_idx;
    logic [6:0] ccnum;
    logic [4:0] n;
  } link_t;

  typedef struct packed {
    logic              we;
    logic [3:0]        idx;
    logic signed [7:0] ctrl;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
  } load_t;

  typedef struct packed {
    logic               hit;
    logic               learned;
    logic [3:0]         idx;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
  } hit_t;

  typedef struct packed {
    logic               we;
    logic [3:0]         idx;
    logic signed [15:0] value;
  } wb_t;

  typedef struct packed {
    logic               v;
    logic               last;
    logic [3:0]         idx;
    logic               learned;
    logic signed [15:0] value;
  } res_t;

endpackage

FILE: design/ccmap_cell.sv
// One fader cell of the scan chain: mapping, bounds and current level.
// Depends on ccmap_pkg.
module ccmap_cell #(
  parameter int IDX           = 0,
  parameter int FRACTION_BITS = ccmap_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ccmap_pkg::link_t    link_i,
  output ccmap_pkg::link_t    link_o,
  input  ccmap_pkg::load_t    load_i,
  input  ccmap_pkg::wb_t      wb_i,
  output ccmap_pkg::hit_t     hit_o,
  output logic signed [15:0]  level_o
);
  import ccmap_pkg::*;

  localparam int UNITY_INT = (FRACTION_BITS >= 15) ? 32767 : (1 << FRACTION_BITS);
  localparam logic signed [15:0] UNITY = 16'(UNITY_INT);

  link_t              link_r, link_nxt;
  logic signed [7:0]  map_r, map_nxt;
  logic signed [15:0] lo_r, lo_nxt;
  logic signed [15:0] hi_r, hi_nxt;
  logic signed [15:0] level_r, level_nxt;
  logic               here;
  logic               learn_here;
  logic               match;

  always_comb begin
    here       = link_i.live && (IDX < int'(link_i.n));
    learn_here = here && link_i.learn && (int'(link_i.learn_idx) == IDX);
    match      = here && (learn_here || (map_r == $signed({1'b0, link_i.ccnum})));

    link_nxt  = link_i;
    map_nxt   = map_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    level_nxt = level_r;
    if (load_i.we && (int'(load_i.idx) == IDX)) begin
      map_nxt = load_i.ctrl;
      lo_nxt  = load_i.lo;
      hi_nxt  = load_i.hi;
    end else if (learn_here) begin
      map_nxt = $signed({1'b0, link_i.ccnum});
    end
    if (wb_i.we && (int'(wb_i.idx) == IDX)) begin
      level_nxt = wb_i.value;
    end

    hit_o.hit     = match;
    hit_o.learned = learn_here;
    hit_o.idx     = 4'(IDX);
    hit_o.lo      = lo_r;
    hit_o.hi      = hi_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r  <= '0;
      map_r   <= -8'sd1;
      lo_r    <= '0;
      hi_r    <= UNITY;
      level_r <= '0;
    end else begin
      link_r  <= link_nxt;
      map_r   <= map_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      level_r <= level_nxt;
    end
  end

  assign link_o  = link_r;
  assign level_o = level_r;

endmodule

FILE: design/ccmap_scale.sv
// Shared scaling pipeline: low + floor((high - low) * value / 127) over three stages.
// Depends on ccmap_pkg.
module ccmap_scale (
  input  logic             clk,
  input  logic             rst_n,
  input  ccmap_pkg::hit_t  hit_i,
  input  logic             end_i,
  input  logic [6:0]       cc_i,
  output ccmap_pkg::res_t  res_o
);
  import ccmap_pkg::*;

  logic                    v1_r, e1_r, l1_r;
  logic [3:0]              idx1_r;
  logic signed [15:0]      lo1_r;
  logic signed [16:0]      diff1_r;
  logic [6:0]              cc1_r;

  logic                    v2_r, e2_r, l2_r;
  logic [3:0]              idx2_r;
  logic signed [15:0]      lo2_r;
  logic signed [24:0]      d2_r;

  logic                    v3_r, e3_r, l3_r, neg3_r;
  logic [3:0]              idx3_r;
  logic signed [15:0]      lo3_r;
  logic [PROD_W-1:0]       p3_r;

  logic signed [16:0]      diff1_nxt;
  logic signed [24:0]      d2_nxt;
  logic [24:0]             du;
  logic [24:0]             x_full;
  logic [PROD_W-1:0]       p3_nxt;
  logic [PROD_W-RECIP_SHIFT-1:0] q;
  logic signed [17:0]      qs;
  logic signed [17:0]      sum;

  always_comb begin
    diff1_nxt = {hit_i.hi[15], hit_i.hi} - {hit_i.lo[15], hit_i.lo};
    d2_nxt    = diff1_r * $signed({1'b0, cc1_r});
    du        = d2_r;
    x_full    = du[24] ? (25'd126 - du) : du;
    p3_nxt    = PROD_W'(x_full[23:0]) * PROD_W'(RECIP_127);
    q         = p3_r[PROD_W-1:RECIP_SHIFT];
    qs        = neg3_r ? -$signed(q) : $signed(q);
    sum       = {{2{lo3_r[15]}}, lo3_r} + qs;

    res_o.v       = v3_r;
    res_o.last    = e3_r;
    res_o.idx     = idx3_r;
    res_o.learned = l3_r;
    res_o.value   = sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      e1_r <= 1'b0;
      v2_r <= 1'b0;
      e2_r <= 1'b0;
      v3_r <= 1'b0;
      e3_r <= 1'b0;
    end else begin
      v1_r <= hit_i.hit;
      e1_r <= end_i;
      v2_r <= v1_r;
      e2_r <= e1_r;
      v3_r <= v2_r;
      e3_r <= e2_r;
    end
  end

  always_ff @(posedge clk) begin
    l1_r    <= hit_i.learned;
    idx1_r  <= hit_i.idx;
    lo1_r   <= hit_i.lo;
    diff1_r <= diff1_nxt;
    cc1_r   <= cc_i;
    l2_r    <= l1_r;
    idx2_r  <= idx1_r;
    lo2_r   <= lo1_r;
    d2_r    <= d2_nxt;
    l3_r    <= l2_r;
    idx3_r  <= idx2_r;
    lo3_r   <= lo2_r;
    neg3_r  <= d2_r[24];
    p3_r    <= p3_nxt;
  end

endmodule

FILE: design/midi_cc_learn_fader_mapper.sv
// Top level of the MIDI control-change fader mapper with controller learn.
// Depends on ccmap_pkg, ccmap_cell and ccmap_scale.
//
// Commands are taken when start is high and busy is low. Arm, cancel and load take
// effect at that edge and produce no word. A read returns one word in the next cycle
// and leaves busy low. A MIDI word that passes the device, channel and status checks
// raises busy and sends a token down a chain of FADER_COUNT cells, one cell a cycle;
// each matching cell hands its bounds to a shared three-stage scaling pipeline.
// Busy stays high until the token has left the last cell and the scaling pipeline has
// emptied, so a new MIDI word is not taken before the last one is through. Dropped
// messages are taken without raising busy and produce no word.
// Result words appear on out_* for one cycle each, marked by out_strobe, in ascending
// fader order; the receiver cannot stall them. One word is held back until the next
// is known, so that the last word of a scan can be flagged by out_final_result when
// the scan ends. Configuration writes are always ready and must be made
// while busy is low. Reset restores all faders to unassigned with range 0 to 1.0,
// levels 0, eight active faders, open filters and learn disarmed.
module midi_cc_learn_fader_mapper #(
  parameter int FADER_COUNT   = ccmap_pkg::FADER_COUNT_DEF,
  parameter int FRACTION_BITS = ccmap_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_operation,
  input  logic [3:0]         in_source_device,
  input  logic [7:0]         in_status_byte,
  input  logic [6:0]         in_first_data_byte,
  input  logic [6:0]         in_second_data_byte,
  input  logic [3:0]         in_target_fader,
  input  logic signed [7:0]  in_assigned_controller,
  input  logic signed [15:0] in_range_low,
  input  logic signed [15:0] in_range_high,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [4:0]         cfg_data,
  output logic               out_strobe,
  output logic [3:0]         out_fader_number,
  output logic signed [15:0] out_fader_value,
  output logic               out_learn_completed,
  output logic               out_final_result
);
  import ccmap_pkg::*;

  localparam int IW = (FADER_COUNT > 1) ? $clog2(FADER_COUNT) : 1;

  logic [4:0]         active_r, active_nxt;
  logic [4:0]         chan_r, chan_nxt;
  logic [4:0]         dev_r, dev_nxt;
  logic               armed_r, armed_nxt;
  logic [3:0]         arm_tgt_r, arm_tgt_nxt;
  logic               busy_r, busy_nxt;
  logic [6:0]         cc_r, cc_nxt;
  link_t              launch_r, launch_nxt;
  logic               hold_v_r, hold_v_nxt;
  logic [3:0]         hold_idx_r, hold_idx_nxt;
  logic               hold_lrn_r, hold_lrn_nxt;
  logic signed [15:0] hold_val_r, hold_val_nxt;
  logic               ostb_r, ostb_nxt;
  logic [3:0]         onum_r, onum_nxt;
  logic signed [15:0] oval_r, oval_nxt;
  logic               olrn_r, olrn_nxt;
  logic               ofin_r, ofin_nxt;

  logic               accept;
  logic [4:0]         n_now;
  logic               tgt_ok;
  logic               msg_ok;
  logic               midi_go;
  logic               learn_go;
  logic [IW-1:0]      rd_idx;
  load_t              load_bus;
  wb_t                wb_bus;
  hit_t               hit_bus;
  res_t               res;
  logic [FADER_COUNT-1:0] hit_vec;

  link_t              links  [FADER_COUNT+1];
  hit_t               hits   [FADER_COUNT];
  logic signed [15:0] levels [FADER_COUNT];

  assign links[0] = launch_r;

  for (genvar g = 0; g < FADER_COUNT; g++) begin : g_cell
    ccmap_cell #(
      .IDX           (g),
      .FRACTION_BITS (FRACTION_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .link_i  (links[g]),
      .link_o  (links[g+1]),
      .load_i  (load_bus),
      .wb_i    (wb_bus),
      .hit_o   (hits[g]),
      .level_o (levels[g])
    );
  end

  always_comb begin
    hit_bus = '0;
    for (int i = 0; i < FADER_COUNT; i++) begin
      hit_vec[i] = hits[i].hit;
      if (hits[i].hit) begin
        hit_bus = hits[i];
      end
    end
  end

  ccmap_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .hit_i (hit_bus),
    .end_i (links[FADER_COUNT].live),
    .cc_i  (cc_r),
    .res_o (res)
  );

  always_comb begin
    accept   = start && !busy_r;
    n_now    = (int'(active_r) > FADER_COUNT) ? 5'(FADER_COUNT) : active_r;
    tgt_ok   = int'(in_target_fader) < FADER_COUNT;
    msg_ok   = ((dev_r == 5'd0) || (({1'b0, in_source_device} + 5'd1) == dev_r)) &&
               ((chan_r == 5'd0) || (({1'b0, in_status_byte[3:0]} + 5'd1) == chan_r)) &&
               (in_status_byte[7:4] == CC_STATUS);
    midi_go  = accept && (in_operation == OP_MIDI) && msg_ok;
    learn_go = midi_go && armed_r && ({1'b0, arm_tgt_r} < n_now);
    rd_idx   = IW'(in_target_fader);

    load_bus.we   = accept && (in_operation == OP_LOAD) && tgt_ok;
    load_bus.idx  = in_target_fader;
    load_bus.ctrl = in_assigned_controller;
    load_bus.lo   = in_range_low;
    load_bus.hi   = in_range_high;

    wb_bus.we    = res.v;
    wb_bus.idx   = res.idx;
    wb_bus.value = res.value;

    active_nxt = active_r;
    chan_nxt   = chan_r;
    dev_nxt    = dev_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ACTIVE:  active_nxt = cfg_data;
        REG_CHANNEL: chan_nxt   = cfg_data;
        REG_DEVICE:  dev_nxt    = cfg_data;
        default:     ;
      endcase
    end

    armed_nxt   = armed_r;
    arm_tgt_nxt = arm_tgt_r;
    if (accept && (in_operation == OP_ARM) && tgt_ok) begin
      armed_nxt   = 1'b1;
      arm_tgt_nxt = in_target_fader;
    end else if (accept && (in_operation == OP_CANCEL)) begin
      armed_nxt = 1'b0;
    end else if (learn_go) begin
      armed_nxt = 1'b0;
    end

    launch_nxt           = '0;
    launch_nxt.live      = midi_go;
    launch_nxt.learn     = learn_go;
    launch_nxt.learn_idx = arm_tgt_r;
    launch_nxt.ccnum     = in_first_data_byte;
    launch_nxt.n         = n_now;
    cc_nxt               = midi_go ? in_second_data_byte : cc_r;

    busy_nxt     = busy_r;
    hold_v_nxt   = hold_v_r;
    hold_idx_nxt = hold_idx_r;
    hold_lrn_nxt = hold_lrn_r;
    hold_val_nxt = hold_val_r;
    ostb_nxt     = 1'b0;
    onum_nxt     = onum_r;
    oval_nxt     = oval_r;
    olrn_nxt     = olrn_r;
    ofin_nxt     = ofin_r;

    if (midi_go) begin
      busy_nxt = 1'b1;
    end

    if (accept && (in_operation == OP_READ)) begin
      ostb_nxt = 1'b1;
      onum_nxt = in_target_fader;
      oval_nxt = (tgt_ok && ({1'b0, in_target_fader} < n_now)) ? levels[rd_idx] : 16'sd0;
      olrn_nxt = 1'b0;
      ofin_nxt = 1'b1;
    end else if (res.v) begin
      if (hold_v_r) begin
        ostb_nxt = 1'b1;
        onum_nxt = hold_idx_r;
        oval_nxt = hold_val_r;
        olrn_nxt = hold_lrn_r;
        ofin_nxt = 1'b0;
      end
      hold_v_nxt   = 1'b1;
      hold_idx_nxt = res.idx;
      hold_lrn_nxt = res.learned;
      hold_val_nxt = res.value;
    end else if (res.last) begin
      if (hold_v_r) begin
        ostb_nxt = 1'b1;
        onum_nxt = hold_idx_r;
        oval_nxt = hold_val_r;
        olrn_nxt = hold_lrn_r;
        ofin_nxt = 1'b1;
      end
      hold_v_nxt = 1'b0;
      busy_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= ACTIVE_RESET;
      chan_r    <= '0;
      dev_r     <= '0;
      armed_r   <= 1'b0;
      arm_tgt_r <= '0;
      busy_r    <= 1'b0;
      launch_r  <= '0;
      hold_v_r  <= 1'b0;
      ostb_r    <= 1'b0;
    end else begin
      active_r  <= active_nxt;
      chan_r    <= chan_nxt;
      dev_r     <= dev_nxt;
      armed_r   <= armed_nxt;
      arm_tgt_r <= arm_tgt_nxt;
      busy_r    <= busy_nxt;
      launch_r  <= launch_nxt;
      hold_v_r  <= hold_v_nxt;
      ostb_r    <= ostb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cc_r       <= cc_nxt;
    hold_idx_r <= hold_idx_nxt;
    hold_lrn_r <= hold_lrn_nxt;
    hold_val_r <= hold_val_nxt;
    onum_r     <= onum_nxt;
    oval_r     <= oval_nxt;
    olrn_r     <= olrn_nxt;
    ofin_r     <= ofin_nxt;
  end

  assign busy                = busy_r;
  assign cfg_ready           = 1'b1;
  assign out_strobe          = ostb_r;
  assign out_fader_number    = onum_r;
  assign out_fader_value     = oval_r;
  assign out_learn_completed = olrn_r;
  assign out_final_result    = ofin_r;

  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(hit_vec))
    else $error("more than one cell matched in one cycle");

  a_launch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    launch_r.live |-> busy_r)
    else $error("scan token launched while not busy");

  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> busy_r)
    else $error("held word present while idle");

  a_end_release: assert property (@(posedge clk) disable iff (!rst_n)
    (res.last && !res.v) |=> !busy_r && !hold_v_r)
    else $error("scan end did not release the block");

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for midi_cc_learn_fader_mapper: directed and random commands,
// config phases, and a scoreboard class that mirrors the fader table and checks each word.
// Depends on ccmap_pkg and the midi_cc_learn_fader_mapper RTL.
module tb_top;
  import ccmap_pkg::*;

  localparam int          CYCLE_LIMIT     = 200000;
  localparam int          SETTLE_CYCLES   = 32;
  localparam int          PHASES          = 10;
  localparam int          PHASE_ITEMS     = 45;
  localparam logic [2:0]  OP_UNUSED_FIRST = 3'd5;
  localparam logic [3:0]  NOTE_ON_STATUS  = 4'h9;

  typedef struct {
    logic [2:0]         op;
    logic [3:0]         dev;
    logic [7:0]         status;
    logic [6:0]         ccnum;
    logic [6:0]         ccval;
    logic [3:0]         target;
    logic signed [7:0]  ctrl;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
  } cmd_t;

  typedef struct {
    logic [3:0]         fader;
    logic signed [15:0] value;
    logic               learned;
    logic               last;
  } word_t;

  class fader_mirror;
    logic [4:0]         active_reg;
    logic [4:0]         channel_reg;
    logic [4:0]         device_reg;
    logic signed [7:0]  ctrl_map [16];
    logic signed [15:0] low_b [16];
    logic signed [15:0] high_b [16];
    logic signed [15:0] level [16];
    logic               learn_armed;
    logic [3:0]         learn_idx;
    word_t              pending_words [$];
    int                 errors;

    function new();
      active_reg  = ACTIVE_RESET;
      channel_reg = '0;
      device_reg  = '0;
      for (int i = 0; i < 16; i++) begin
        ctrl_map[i] = -8'sd1;
        low_b[i]    = '0;
        high_b[i]   = 16'(1 << FRACTION_BITS_DEF);
        level[i]    = '0;
      end
      learn_armed = 1'b0;
      learn_idx   = '0;
      errors      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [4:0] data);
      case (idx)
        REG_ACTIVE:  active_reg = data;
        REG_CHANNEL: channel_reg = data;
        REG_DEVICE:  device_reg = data;
        default: ;
      endcase
    endfunction

    function logic signed [15:0] scaled(logic signed [15:0] lo, logic signed [15:0] hi,
                                        logic [6:0] cc);
      int span;
      int quot;
      span = (int'(hi) - int'(lo)) * int'(cc);
      if (span >= 0) quot = span / 127;
      else quot = -((-span + 126) / 127);
      return 16'(int'(lo) + quot);
    endfunction

    function void take_command(cmd_t c);
      int    n;
      int    first;
      logic  learned_ok;
      logic [3:0] learned_at;
      word_t w;
      n = (active_reg > 5'd16) ? 16 : int'(active_reg);
      learned_ok = 1'b0;
      learned_at = '0;
      case (c.op)
        OP_MIDI: begin
          if (device_reg != 0 && int'(c.dev) != int'(device_reg) - 1) return;
          if (channel_reg != 0 && int'(c.status[3:0]) + 1 != int'(channel_reg)) return;
          if (c.status[7:4] != CC_STATUS) return;
          if (learn_armed && int'(learn_idx) < n) begin
            ctrl_map[learn_idx] = {1'b0, c.ccnum};
            learned_ok = 1'b1;
            learned_at = learn_idx;
            learn_armed = 1'b0;
          end
          first = pending_words.size();
          for (int i = 0; i < n; i++) begin
            if (int'(ctrl_map[i]) == int'(c.ccnum)) begin
              level[i]  = scaled(low_b[i], high_b[i], c.ccval);
              w.fader   = 4'(i);
              w.value   = level[i];
              w.learned = learned_ok && learned_at == 4'(i);
              w.last    = 1'b0;
              pending_words = {pending_words, w};
            end
          end
          if (pending_words.size() > first) begin
            pending_words[pending_words.size() - 1].last = 1'b1;
          end
        end
        OP_ARM: begin
          learn_armed = 1'b1;
          learn_idx = c.target;
        end
        OP_CANCEL: learn_armed = 1'b0;
        OP_LOAD: begin
          ctrl_map[c.target] = c.ctrl;
          low_b[c.target]    = c.lo;
          high_b[c.target]   = c.hi;
        end
        OP_READ: begin
          w.fader   = c.target;
          w.value   = (int'(c.target) < n) ? level[c.target] : 16'sd0;
          w.learned = 1'b0;
          w.last    = 1'b1;
          pending_words = {pending_words, w};
        end
        default: ;
      endcase
    endfunction

    function void check_word(logic [3:0] fader, logic signed [15:0] value, logic learned,
                             logic last);
      word_t w;
      if (pending_words.size() == 0) begin
        $error("unexpected word: fader_number %0d fader_value %0d", fader, value);
        errors++;
        return;
      end
      w = pending_words.pop_front();
      if (w.fader !== fader) begin
        $error("fader_number: expected %0d, actual %0d", w.fader, fader);
        errors++;
      end
      if (w.value !== value) begin
        $error("fader_value: expected %0d, actual %0d", w.value, value);
        errors++;
      end
      if (w.learned !== learned) begin
        $error("learn_completed: expected %0b, actual %0b", w.learned, learned);
        errors++;
      end
      if (w.last !== last) begin
        $error("final_result: expected %0b, actual %0b", w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_operation;
  logic [3:0]         in_source_device;
  logic [7:0]         in_status_byte;
  logic [6:0]         in_first_data_byte;
  logic [6:0]         in_second_data_byte;
  logic [3:0]         in_target_fader;
  logic signed [7:0]  in_assigned_controller;
  logic signed [15:0] in_range_low;
  logic signed [15:0] in_range_high;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [4:0]         cfg_data;
  logic               out_strobe;
  logic [3:0]         out_fader_number;
  logic signed [15:0] out_fader_value;
  logic               out_learn_completed;
  logic               out_final_result;

  fader_mirror mirror;
  int unsigned cycle_count = 0;

  midi_cc_learn_fader_mapper dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_operation           (in_operation),
    .in_source_device       (in_source_device),
    .in_status_byte         (in_status_byte),
    .in_first_data_byte     (in_first_data_byte),
    .in_second_data_byte    (in_second_data_byte),
    .in_target_fader        (in_target_fader),
    .in_assigned_controller (in_assigned_controller),
    .in_range_low           (in_range_low),
    .in_range_high          (in_range_high),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .out_strobe             (out_strobe),
    .out_fader_number       (out_fader_number),
    .out_fader_value        (out_fader_value),
    .out_learn_completed    (out_learn_completed),
    .out_final_result       (out_final_result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      mirror.check_word(out_fader_number, out_fader_value, out_learn_completed,
                        out_final_result);
    end
  end

  task automatic send(input cmd_t c);
    @(negedge clk);
    start                  = 1'b1;
    in_operation           = c.op;
    in_source_device       = c.dev;
    in_status_byte         = c.status;
    in_first_data_byte     = c.ccnum;
    in_second_data_byte    = c.ccval;
    in_target_fader        = c.target;
    in_assigned_controller = c.ctrl;
    in_range_low           = c.lo;
    in_range_high          = c.hi;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    mirror.take_command(c);
  endtask

  task automatic pause(input int cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (mirror.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    mirror.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input logic [4:0] active, input logic [4:0] channel,
                           input logic [4:0] device);
    drain();
    write_reg(REG_ACTIVE, active);
    write_reg(REG_CHANNEL, channel);
    write_reg(REG_DEVICE, device);
  endtask

  function automatic cmd_t make_cmd(logic [2:0] op, logic [3:0] target, logic [6:0] ccnum,
                                    logic [6:0] ccval, logic signed [7:0] ctrl,
                                    logic signed [15:0] lo, logic signed [15:0] hi);
    cmd_t c;
    c.op = op;
    c.dev = '0;
    c.status = {CC_STATUS, 4'h0};
    c.ccnum = ccnum;
    c.ccval = ccval;
    c.target = target;
    c.ctrl = ctrl;
    c.lo = lo;
    c.hi = hi;
    return c;
  endfunction

  function automatic logic [6:0] pooled_controller();
    case ($urandom_range(0, 3))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd2;
      default: return 7'd127;
    endcase
  endfunction

  function automatic logic signed [15:0] random_bound();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    c.op     = OP_MIDI;
    c.dev    = 4'($urandom);
    c.status = 8'($urandom);
    c.ccnum  = 7'($urandom);
    c.ccval  = 7'($urandom);
    c.target = 4'($urandom);
    c.ctrl   = 8'($urandom);
    c.lo     = random_bound();
    c.hi     = random_bound();
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      if ($urandom_range(0, 9) < 8) begin
        c.status[7:4] = CC_STATUS;
        if (mirror.channel_reg inside {[1:16]}) c.status[3:0] = 4'(mirror.channel_reg - 1);
        if (mirror.device_reg inside {[1:16]}) c.dev = 4'(mirror.device_reg - 1);
        c.ccnum = pooled_controller();
      end
    end else if (pick < 60) begin
      c.op = OP_ARM;
    end else if (pick < 64) begin
      c.op = OP_CANCEL;
    end else if (pick < 80) begin
      c.op = OP_LOAD;
      if ($urandom_range(0, 9) < 8) c.ctrl = {1'b0, pooled_controller()};
    end else if (pick < 95) begin
      c.op = OP_READ;
    end else begin
      c.op = OP_UNUSED_FIRST + 3'($urandom_range(0, 2));
    end
    return c;
  endfunction

  initial begin
    cmd_t c;
    mirror = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_MIDI;
    in_source_device = '0;
    in_status_byte = '0;
    in_first_data_byte = '0;
    in_second_data_byte = '0;
    in_target_fader = '0;
    in_assigned_controller = '0;
    in_range_low = '0;
    in_range_high = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ACTIVE;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send(make_cmd(OP_READ, 4'd0, 7'd0, 7'd0, 8'sd0, 16'sd0, 16'sd0));
    send(make_cmd(OP_MIDI, 4'd0, 7'd16, 7'd64, 8'sd0, 16'sd0, 16'sd0));
    send(make_cmd(OP_ARM, 4'd3, 7'd0, 7'd0, 8'sd0, 16'sd0, 16'sd0));
    send(make_cmd(OP_MIDI, 4'd0, 7'd16, 7'd127, 8'sd0, 16'sd0, 16'sd0));
    send(make_cmd(OP_LOAD, 4'd0, 7'd0, 7'd0, 8'sd16, 16'sh8000, 16'sh7fff));
    send(make_cmd(OP_LOAD, 4'd7, 7'd0, 7'd0, 8'sd16, 16'sh7fff, 16'sh8000));
    send(make_cmd(OP_MIDI, 4'd0, 7'd16, 7'd0, 8'sd0, 16'sd0, 16'sd0));
    send(make_cmd(OP_MIDI, 4'd0, 7'd16, 7'd127, 8'sd0, 16'sd0, 16'sd0));
    send(make_cmd(OP_MIDI, 4'd0, 7'd16, 7'd1, 8'sd0, 16'sd0, 16'sd0));
    c = make_cmd(OP_MIDI, 4'd0, 7'd16, 7'd100, 8'sd0, 16'sd0, 16'sd0);
    c.status = {NOTE_ON_STATUS, 4'h0};
    send(c);
    c = make_cmd(OP_MIDI, 4'd0, 7'd16, 7'd5, 8'sd0, 16'sd0, 16'sd0);
    c.status = {CC_STATUS, 4'hf};
    c.dev = 4'd15;
    send(c);
    send(make_cmd(OP_LOAD, 4'd15, 7'd0, 7'd0, 8'sd16, 16'sd1, 16'sd2));
    send(make_cmd(OP_READ, 4'd15, 7'd0, 7'd0, 8'sd0, 16'sd0, 16'sd0));
    send(make_cmd(OP_ARM, 4'd12, 7'd0, 7'd0, 8'sd0, 16'sd0, 16'sd0));
    send(make_cmd(OP_MIDI, 4'd0, 7'd16, 7'd77, 8'sd0, 16'sd0, 16'sd0));
    send(make_cmd(OP_CANCEL, 4'd0, 7'd0, 7'd0, 8'sd0, 16'sd0, 16'sd0));
    send(make_cmd(OP_MIDI, 4'd0, 7'd20, 7'd10, 8'sd0, 16'sd0, 16'sd0));
    send(make_cmd(OP_LOAD, 4'd1, 7'd0, 7'd0, -8'sd128, 16'sd0, 16'sd100));
    send(make_cmd(OP_MIDI, 4'd0, 7'd0, 7'd50, 8'sd0, 16'sd0, 16'sd0));
    send(make_cmd(OP_ARM, 4'd2, 7'd0, 7'd0, 8'sd0, 16'sd0, 16'sd0));
    send(make_cmd(OP_ARM, 4'd4, 7'd0, 7'd0, 8'sd0, 16'sd0, 16'sd0));
    send(make_cmd(OP_MIDI, 4'd0, 7'd99, 7'd127, 8'sd0, 16'sd0, 16'sd0));
    send(make_cmd(OP_UNUSED_FIRST, 4'd0, 7'd0, 7'd0, 8'sd0, 16'sd0, 16'sd0));
    send(make_cmd(OP_UNUSED_FIRST + 3'd2, 4'd0, 7'd0, 7'd0, 8'sd0, 16'sd0, 16'sd0));
    send(make_cmd(OP_READ, 4'd4, 7'd0, 7'd0, 8'sd0, 16'sd0, 16'sd0));

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: configure(5'd16, 5'd0, 5'd0);
        1: configure(5'd1, 5'd1, 5'd1);
        2: configure(5'd16, 5'd16, 5'd16);
        3: configure(5'd0, 5'd31, 5'd0);
        4: configure(5'd17, 5'd17, 5'd5);
        5: configure(5'd31, 5'd3, 5'd17);
        PHASES - 1: configure(5'd16, 5'd0, 5'd0);
        default: configure(5'($urandom_range(1, 16)), 5'($urandom_range(0, 16)),
                           5'($urandom_range(0, 16)));
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph != PHASES - 1) begin
          if ($urandom_range(0, 9) == 0) pause($urandom_range(1, 12));
          if ($urandom_range(0, 99) == 0) drain();
        end
        send(random_cmd());
      end
    end

    drain();
    if (mirror.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/ccmap_pkg.sv
design/ccmap_cell.sv
design/ccmap_scale.sv
design/midi_cc_learn_fader_mapper.sv
bench/tb_top.sv
